// ----- hw/rtl/capture_period_to_temperature_unit_macros.svh -----
// Assertion helpers for the capture period unit.
`ifndef CAPTURE_PERIOD_TO_TEMPERATURE_UNIT_MACROS_SVH
`define CAPTURE_PERIOD_TO_TEMPERATURE_UNIT_MACROS_SVH

// Property checked at every edge outside reset.
`define CPT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/cpt_pkg.sv -----
package cpt_pkg;

  // Sequencer program counter width
  localparam int unsigned PcW = 4;

  // Divider step counter
  localparam int unsigned CntW = 6;
  localparam logic [CntW-1:0] DivFreqSteps = 6'd40;
  localparam logic [CntW-1:0] DivTempSteps = 6'd24;

  // Register indexes
  localparam logic [1:0] RegTicksPerSecond = 2'd0;
  localparam logic [1:0] RegHzPerDegree    = 2'd1;

  // Register reset values
  localparam logic [31:0] TicksPerSecondReset = 32'd1000000;
  localparam logic [7:0]  HzPerDegreeReset    = 8'd10;

  // Result status codes
  localparam logic [1:0] StatusFirst = 2'd0;
  localparam logic [1:0] StatusValid = 2'd1;
  localparam logic [1:0] StatusZero  = 2'd2;

  // Datapath operations
  typedef enum logic [2:0] {
    OpNop,
    OpCapture,
    OpFreqInit,
    OpDivStep,
    OpTempInit,
    OpResValid,
    OpResFirst,
    OpResZero
  } op_e;

  // Jump conditions
  typedef enum logic [2:0] {
    CondNever,
    CondAlways,
    CondNoStart,
    CondFirst,
    CondZero,
    CondMore,
    CondOutBusy
  } cond_e;

  // One microcode word
  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic [PcW-1:0] target;
    logic           in_rdy;
    logic           done;
  } ctrl_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic first;
    logic zero;
    logic more;
  } flags_t;

  // Program addresses
  localparam logic [PcW-1:0] AddrWait     = 4'd0;
  localparam logic [PcW-1:0] AddrDivFreq  = 4'd4;
  localparam logic [PcW-1:0] AddrDivTemp  = 4'd6;
  localparam logic [PcW-1:0] AddrResFirst = 4'd8;
  localparam logic [PcW-1:0] AddrResZero  = 4'd9;
  localparam logic [PcW-1:0] AddrEmit     = 4'd10;

  // Microcode program: wait, capture checks, two divisions, result, emit, return
  function automatic ctrl_t ucode_rom(input logic [PcW-1:0] addr);
    ctrl_t w;
    w = '{op: OpNop, cond: CondNever, target: AddrWait, in_rdy: 1'b0, done: 1'b0};
    case (addr)
      4'd0: w = '{op: OpCapture, cond: CondNoStart, target: AddrWait,
                  in_rdy: 1'b1, done: 1'b0};
      4'd1: w = '{op: OpNop, cond: CondFirst, target: AddrResFirst,
                  in_rdy: 1'b0, done: 1'b0};
      4'd2: w = '{op: OpNop, cond: CondZero, target: AddrResZero,
                  in_rdy: 1'b0, done: 1'b0};
      4'd3: w = '{op: OpFreqInit, cond: CondNever, target: AddrWait,
                  in_rdy: 1'b0, done: 1'b0};
      4'd4: w = '{op: OpDivStep, cond: CondMore, target: AddrDivFreq,
                  in_rdy: 1'b0, done: 1'b0};
      4'd5: w = '{op: OpTempInit, cond: CondNever, target: AddrWait,
                  in_rdy: 1'b0, done: 1'b0};
      4'd6: w = '{op: OpDivStep, cond: CondMore, target: AddrDivTemp,
                  in_rdy: 1'b0, done: 1'b0};
      4'd7: w = '{op: OpResValid, cond: CondAlways, target: AddrEmit,
                  in_rdy: 1'b0, done: 1'b0};
      4'd8: w = '{op: OpResFirst, cond: CondAlways, target: AddrEmit,
                  in_rdy: 1'b0, done: 1'b0};
      4'd9: w = '{op: OpResZero, cond: CondNever, target: AddrWait,
                  in_rdy: 1'b0, done: 1'b0};
      4'd10: w = '{op: OpNop, cond: CondOutBusy, target: AddrEmit,
                   in_rdy: 1'b0, done: 1'b1};
      4'd11: w = '{op: OpNop, cond: CondAlways, target: AddrWait,
                   in_rdy: 1'b0, done: 1'b0};
      default: w = '{op: OpNop, cond: CondAlways, target: AddrWait,
                     in_rdy: 1'b0, done: 1'b0};
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/capture_period_to_temperature_unit.sv -----
// Capture period to temperature unit.
// Input channel (in_valid_i / in_ready_o) takes one 32-bit timer capture per item.
// Output channel (out_valid_o / out_ready_i) returns one result item per capture:
// status, period in ticks, frequency and temperature, both with 8 fraction bits.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i (0 tick rate,
// 1 hertz per degree); other indexes are ignored. Write only while idle.
// Throughput: one item at a time. From accept to the next accept a full result
// passes the check steps, a setup step and a 40-step divide for the frequency,
// one setup step and a 24-step divide for the temperature on one shared restoring
// divider, then result, emit and return steps; out_valid_o rises after the emit.
// A first capture skips the divider and goes from the check steps straight to the
// result, emit and return steps; a zero period skips the divider as well.
// The result sits in an output register, so a new capture is accepted while the
// receiver still holds off the last one. A stalled receiver holds the sequencer
// at its emit step once a second result is ready; ready returns after the emit
// and return steps. Reset clears the first-capture flag to pending, the previous
// capture to zero, the registers to their defaults and empties the output register.
`include "capture_period_to_temperature_unit_macros.svh"

module capture_period_to_temperature_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] capture_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] period_ticks_o,
  output logic [39:0] frequency_q8_o,
  output logic [23:0] temperature_q8_o
);

  logic [31:0]     tps_q;
  logic [7:0]      hz_q;
  cpt_pkg::ctrl_t  ctrl;
  cpt_pkg::flags_t flags;
  logic            start;
  logic            out_busy;
  logic            emit;
  logic [1:0]      res_status;
  logic [31:0]     res_period;
  logic [39:0]     res_freq;
  logic [23:0]     res_temp;

  logic            out_valid_q;
  logic [1:0]      out_status_q;
  logic [31:0]     out_period_q;
  logic [39:0]     out_freq_q;
  logic [23:0]     out_temp_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= cpt_pkg::TicksPerSecondReset;
      hz_q  <= cpt_pkg::HzPerDegreeReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == cpt_pkg::RegTicksPerSecond) begin
        tps_q <= cfg_data_i;
      end else if (cfg_index_i == cpt_pkg::RegHzPerDegree) begin
        hz_q <= cfg_data_i[7:0];
      end
    end
  end

  // Handshake glue
  assign in_ready_o = ctrl.in_rdy;
  assign start      = in_valid_i && ctrl.in_rdy;
  assign out_busy   = out_valid_q && !out_ready_i;
  assign emit       = ctrl.done && !out_busy;

  cpt_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .out_busy_i (out_busy),
    .flags_i    (flags),
    .ctrl_o     (ctrl)
  );

  cpt_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .op_i               (ctrl.op),
    .start_i            (start),
    .capture_value_i    (capture_value_i),
    .ticks_per_second_i (tps_q),
    .hz_per_degree_i    (hz_q),
    .flags_o            (flags),
    .status_o           (res_status),
    .period_ticks_o     (res_period),
    .frequency_q8_o     (res_freq),
    .temperature_q8_o   (res_temp)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_status_q <= res_status;
      out_period_q <= res_period;
      out_freq_q   <= res_freq;
      out_temp_q   <= res_temp;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign period_ticks_o   = out_period_q;
  assign frequency_q8_o   = out_freq_q;
  assign temperature_q8_o = out_temp_q;

  // Checks
  `CPT_ASSERT(a_no_accept_while_emit, clk_i, rst_ni, !(in_ready_o && emit),
    "input accepted in the emit step")
  `CPT_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, start, !in_ready_o,
    "ready stayed high after an accepted item")
  `CPT_ASSERT(a_status_code, clk_i, rst_ni, !out_valid_o || status_o != 2'd3,
    "undefined status code")
  `CPT_ASSERT(a_no_result_fields, clk_i, rst_ni,
    !(out_valid_o && status_o != cpt_pkg::StatusValid) ||
    (period_ticks_o == '0 && frequency_q8_o == '0 && temperature_q8_o == '0),
    "nonzero fields on a result without a measurement")

endmodule

// ----- hw/rtl/cpt_seq.sv -----
module cpt_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              out_busy_i,
  input  cpt_pkg::flags_t   flags_i,
  output cpt_pkg::ctrl_t    ctrl_o
);

  logic [cpt_pkg::PcW-1:0] pc_q, pc_d;
  logic                    take;

  // Control word of the current step
  assign ctrl_o = cpt_pkg::ucode_rom(pc_q);

  // Jump condition
  always_comb begin
    case (ctrl_o.cond)
      cpt_pkg::CondNever:   take = 1'b0;
      cpt_pkg::CondAlways:  take = 1'b1;
      cpt_pkg::CondNoStart: take = !start_i;
      cpt_pkg::CondFirst:   take = flags_i.first;
      cpt_pkg::CondZero:    take = flags_i.zero;
      cpt_pkg::CondMore:    take = flags_i.more;
      cpt_pkg::CondOutBusy: take = out_busy_i;
      default:              take = 1'b1;
    endcase
  end

  assign pc_d = take ? ctrl_o.target : pc_q + 4'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= cpt_pkg::AddrWait;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ----- hw/rtl/cpt_datapath.sv -----
module cpt_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cpt_pkg::op_e     op_i,
  input  logic             start_i,
  input  logic [31:0]      capture_value_i,
  input  logic [31:0]      ticks_per_second_i,
  input  logic [7:0]       hz_per_degree_i,
  output cpt_pkg::flags_t  flags_o,
  output logic [1:0]       status_o,
  output logic [31:0]      period_ticks_o,
  output logic [39:0]      frequency_q8_o,
  output logic [23:0]      temperature_q8_o
);

  // Capture state
  logic        first_q, first_d;
  logic        is_first_q, is_first_d;
  logic        zero_q, zero_d;
  logic [31:0] prev_q, prev_d;
  logic [31:0] period_q, period_d;

  // Shared restoring divider
  logic [39:0]               num_q, num_d;
  logic [31:0]               rem_q, rem_d;
  logic [31:0]               den_q, den_d;
  logic [cpt_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [32:0]               trial;
  logic [32:0]               diff;
  logic                      ge;

  // Intermediate and result registers
  logic [39:0] freq_q, freq_d;
  logic        sat_q, sat_d;
  logic [1:0]  res_status_q, res_status_d;
  logic [31:0] res_period_q, res_period_d;
  logic [39:0] res_freq_q, res_freq_d;
  logic [23:0] res_temp_q, res_temp_d;

  // One quotient bit per step
  assign trial = {rem_q, num_q[39]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    first_d      = first_q;
    is_first_d   = is_first_q;
    zero_d       = zero_q;
    prev_d       = prev_q;
    period_d     = period_q;
    num_d        = num_q;
    rem_d        = rem_q;
    den_d        = den_q;
    cnt_d        = cnt_q;
    freq_d       = freq_q;
    sat_d        = sat_q;
    res_status_d = res_status_q;
    res_period_d = res_period_q;
    res_freq_d   = res_freq_q;
    res_temp_d   = res_temp_q;
    case (op_i)
      cpt_pkg::OpCapture: begin
        if (start_i) begin
          period_d   = capture_value_i - prev_q;
          zero_d     = capture_value_i == prev_q;
          prev_d     = capture_value_i;
          is_first_d = first_q;
          first_d    = 1'b0;
        end
      end
      cpt_pkg::OpFreqInit: begin
        num_d = {ticks_per_second_i, 8'h00};
        rem_d = '0;
        den_d = period_q;
        cnt_d = cpt_pkg::DivFreqSteps;
      end
      cpt_pkg::OpDivStep: begin
        rem_d = ge ? diff[31:0] : trial[31:0];
        num_d = {num_q[38:0], ge};
        cnt_d = cnt_q - 6'd1;
      end
      cpt_pkg::OpTempInit: begin
        // The quotient fits 24 bits only when the top 16 bits are below the
        // scale; a zero scale always saturates here.
        freq_d = num_q;
        sat_d  = num_q[39:24] >= {8'h00, hz_per_degree_i};
        num_d  = {num_q[23:0], 16'h0000};
        rem_d  = {16'h0000, num_q[39:24]};
        den_d  = {24'h000000, hz_per_degree_i};
        cnt_d  = cpt_pkg::DivTempSteps;
      end
      cpt_pkg::OpResValid: begin
        res_status_d = cpt_pkg::StatusValid;
        res_period_d = period_q;
        res_freq_d   = freq_q;
        res_temp_d   = sat_q ? 24'hFFFFFF : num_q[23:0];
      end
      cpt_pkg::OpResFirst: begin
        res_status_d = cpt_pkg::StatusFirst;
        res_period_d = '0;
        res_freq_d   = '0;
        res_temp_d   = '0;
      end
      cpt_pkg::OpResZero: begin
        res_status_d = cpt_pkg::StatusZero;
        res_period_d = '0;
        res_freq_d   = '0;
        res_temp_d   = '0;
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q    <= 1'b1;
      is_first_q <= 1'b0;
      zero_q     <= 1'b0;
      prev_q     <= '0;
      cnt_q      <= '0;
    end else begin
      first_q    <= first_d;
      is_first_q <= is_first_d;
      zero_q     <= zero_d;
      prev_q     <= prev_d;
      cnt_q      <= cnt_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    period_q     <= period_d;
    num_q        <= num_d;
    rem_q        <= rem_d;
    den_q        <= den_d;
    freq_q       <= freq_d;
    sat_q        <= sat_d;
    res_status_q <= res_status_d;
    res_period_q <= res_period_d;
    res_freq_q   <= res_freq_d;
    res_temp_q   <= res_temp_d;
  end

  assign flags_o.first = is_first_q;
  assign flags_o.zero  = zero_q;
  assign flags_o.more  = cnt_q != 6'd1;

  assign status_o         = res_status_q;
  assign period_ticks_o   = res_period_q;
  assign frequency_q8_o   = res_freq_q;
  assign temperature_q8_o = res_temp_q;

endmodule
